// ===== src/hsi2rgbw_pkg.sv =====
// Shared types, constants and the Q28 product helper for the ratio table of the HSI to RGB/RGBW
// converter. No dependencies; every other file of the block imports this package.
`default_nettype none
package hsi2rgbw_pkg;

  localparam int unsigned HUE_W         = 16;
  localparam int unsigned SAT_W         = 17;
  localparam int unsigned CHAN_W        = 8;
  localparam int unsigned FRACTION_BITS = 16;
  localparam logic [SAT_W-1:0] ONE      = SAT_W'(1) << FRACTION_BITS;

  localparam int unsigned RATIO_TABLE_ENTRIES = 1024;
  localparam int unsigned RATIO_W             = 17;
  localparam int unsigned FACTOR_W            = 18;
  localparam int unsigned QUEUE_DEPTH         = 4;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_IDX_OUTPUT_MODE = 1'b0;

  localparam int unsigned ANG_FRAC = 28;
  localparam longint      ANG_120  = 64'sd562209904;
  localparam longint      ANG_60   = 64'sd281104952;
  localparam longint      Q14_ONE  = 64'sd16384;
  localparam longint      Q28_ONE  = 64'sd1 << ANG_FRAC;

  typedef enum logic [1:0] {
    SECT_R = 2'd0,
    SECT_G = 2'd1,
    SECT_B = 2'd2
  } sector_e;

  typedef enum logic {
    MODE_RGB  = 1'b0,
    MODE_RGBW = 1'b1
  } mode_e;

  typedef struct packed {
    sector_e                    sector;
    logic signed [RATIO_W-1:0]  ratio;
    logic        [SAT_W-1:0]    sat;
    logic        [SAT_W-1:0]    inten;
  } item_t;

  function automatic longint qmul_q28(input longint a, input longint b);
    return (a * b) >>> ANG_FRAC;
  endfunction

endpackage
`default_nettype wire

// ===== src/hsi2rgbw_in_if.sv =====
// Pixel input channel: valid/ready handshake with hue, saturation and intensity.
// Depends on hsi2rgbw_pkg for the field widths.
`default_nettype none
interface hsi2rgbw_in_if;
  import hsi2rgbw_pkg::*;

  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [SAT_W-1:0] saturation;
  logic [SAT_W-1:0] intensity;

  modport source (output valid, hue, saturation, intensity, input ready);
  modport sink   (input valid, hue, saturation, intensity, output ready);
endinterface
`default_nettype wire

// ===== src/hsi2rgbw_out_if.sv =====
// LED channel output: valid/ready handshake with red, green, blue and white bytes.
// Depends on hsi2rgbw_pkg for the field widths.
`default_nettype none
interface hsi2rgbw_out_if;
  import hsi2rgbw_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] white;

  modport source (output valid, red, green, blue, white, input ready);
  modport sink   (input valid, red, green, blue, white, output ready);
endinterface
`default_nettype wire

// ===== src/hsi2rgbw_front.sv =====
// Front end: accepts pixels, clamps, picks the hue sector and reads the ratio table.
// Depends on hsi2rgbw_pkg and hsi2rgbw_in_if.
`default_nettype none
module hsi2rgbw_front #(
  parameter int unsigned RATIO_TABLE_ENTRIES = hsi2rgbw_pkg::RATIO_TABLE_ENTRIES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  hsi2rgbw_in_if.sink         in_i,
  output logic                item_valid_o,
  input  logic                item_ready_i,
  output hsi2rgbw_pkg::item_t item_o
);
  import hsi2rgbw_pkg::*;

  localparam int unsigned IDX_W  = $clog2(RATIO_TABLE_ENTRIES);
  localparam int unsigned PROD_W = IDX_W + HUE_W;

  logic signed [RATIO_W-1:0] rom_tbl [RATIO_TABLE_ENTRIES];

  for (genvar k = 0; k < RATIO_TABLE_ENTRIES; k++) begin : g_rom
    localparam longint X       = (longint'(k) * ANG_120) / longint'(RATIO_TABLE_ENTRIES);
    localparam longint NY      = qmul_q28(X, X);
    localparam longint N1      = qmul_q28(Q28_ONE, NY) / 64'sd2;
    localparam longint N2      = qmul_q28(N1, NY) / 64'sd12;
    localparam longint N3      = qmul_q28(N2, NY) / 64'sd30;
    localparam longint N4      = qmul_q28(N3, NY) / 64'sd56;
    localparam longint N5      = qmul_q28(N4, NY) / 64'sd90;
    localparam longint N6      = qmul_q28(N5, NY) / 64'sd132;
    localparam longint N7      = qmul_q28(N6, NY) / 64'sd182;
    localparam longint N8      = qmul_q28(N7, NY) / 64'sd240;
    localparam longint N9      = qmul_q28(N8, NY) / 64'sd306;
    localparam longint N10     = qmul_q28(N9, NY) / 64'sd380;
    localparam longint N11     = qmul_q28(N10, NY) / 64'sd462;
    localparam longint N12     = qmul_q28(N11, NY) / 64'sd552;
    localparam longint NUM     = Q28_ONE - N1 + N2 - N3 + N4 - N5 + N6
                                 - N7 + N8 - N9 + N10 - N11 + N12;
    localparam longint DA      = ANG_60 - X;
    localparam longint DU      = (DA < 0) ? -DA : DA;
    localparam longint DY      = qmul_q28(DU, DU);
    localparam longint D1      = qmul_q28(Q28_ONE, DY) / 64'sd2;
    localparam longint D2      = qmul_q28(D1, DY) / 64'sd12;
    localparam longint D3      = qmul_q28(D2, DY) / 64'sd30;
    localparam longint D4      = qmul_q28(D3, DY) / 64'sd56;
    localparam longint D5      = qmul_q28(D4, DY) / 64'sd90;
    localparam longint D6      = qmul_q28(D5, DY) / 64'sd132;
    localparam longint D7      = qmul_q28(D6, DY) / 64'sd182;
    localparam longint D8      = qmul_q28(D7, DY) / 64'sd240;
    localparam longint D9      = qmul_q28(D8, DY) / 64'sd306;
    localparam longint D10     = qmul_q28(D9, DY) / 64'sd380;
    localparam longint D11     = qmul_q28(D10, DY) / 64'sd462;
    localparam longint D12     = qmul_q28(D11, DY) / 64'sd552;
    localparam longint DEN_RAW = Q28_ONE - D1 + D2 - D3 + D4 - D5 + D6
                                 - D7 + D8 - D9 + D10 - D11 + D12;
    localparam longint DEN     = (DEN_RAW <= 0) ? 64'sd1 : DEN_RAW;
    localparam longint MAG     = (NUM < 0) ? -NUM : NUM;
    localparam longint RQ      = (MAG * Q14_ONE + DEN / 2) / DEN;
    localparam longint RS      = (NUM < 0) ? -RQ : RQ;
    assign rom_tbl[k] = RATIO_W'(RS);
  end

  logic                 s1_valid_q;
  sector_e              s1_sector_q;
  logic [IDX_W-1:0]     s1_idx_q;
  logic [SAT_W-1:0]     s1_sat_q;
  logic [SAT_W-1:0]     s1_int_q;
  logic                 s2_valid_q;
  item_t                s2_item_q;

  logic                 s1_adv;
  logic                 s2_adv;
  logic [HUE_W+1:0]     h3;
  logic [PROD_W-1:0]    idx_prod;
  logic [SAT_W-1:0]     sat_c;
  logic [SAT_W-1:0]     int_c;

  assign s2_adv     = !s2_valid_q || item_ready_i;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign in_i.ready = s1_adv;

  assign h3       = (HUE_W + 2)'(in_i.hue) * (HUE_W + 2)'(3);
  assign idx_prod = PROD_W'(h3[HUE_W-1:0]) * PROD_W'(RATIO_TABLE_ENTRIES);
  assign sat_c    = (in_i.saturation > ONE) ? ONE : in_i.saturation;
  assign int_c    = (in_i.intensity > ONE) ? ONE : in_i.intensity;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= in_i.valid;
      end
      if (s2_adv) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_i.valid) begin
      s1_sector_q <= sector_e'(h3[HUE_W+1:HUE_W]);
      s1_idx_q    <= idx_prod[PROD_W-1:HUE_W];
      s1_sat_q    <= sat_c;
      s1_int_q    <= int_c;
    end
    if (s2_adv && s1_valid_q) begin
      s2_item_q.sector <= s1_sector_q;
      s2_item_q.ratio  <= rom_tbl[s1_idx_q];
      s2_item_q.sat    <= s1_sat_q;
      s2_item_q.inten  <= s1_int_q;
    end
  end

  assign item_valid_o = s2_valid_q;
  assign item_o       = s2_item_q;

endmodule
`default_nettype wire

// ===== src/hsi2rgbw_fifo.sv =====
// Short queue between front and back end, built from flip-flops.
// Depends on hsi2rgbw_pkg for the entry type.
`default_nettype none
module hsi2rgbw_fifo #(
  parameter int unsigned DEPTH = hsi2rgbw_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_valid_i,
  output logic                wr_ready_o,
  input  hsi2rgbw_pkg::item_t wr_item_i,
  output logic                rd_valid_o,
  input  logic                rd_ready_i,
  output hsi2rgbw_pkg::item_t rd_item_o
);
  import hsi2rgbw_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t             mem_q [DEPTH];
  logic [PTR_W-1:0]  wptr_q, wptr_d;
  logic [PTR_W-1:0]  rptr_q, rptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              push;
  logic              pop;

  assign wr_ready_o = (count_q != CNT_W'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_item_o  = mem_q[rptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_item_i;
    end
  end

endmodule
`default_nettype wire

// ===== src/hsi2rgbw_back.sv =====
// Back end: sector factors, intensity products, byte scaling and channel routing.
// Depends on hsi2rgbw_pkg and hsi2rgbw_out_if.
`default_nettype none
module hsi2rgbw_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hsi2rgbw_pkg::mode_e mode_i,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  input  hsi2rgbw_pkg::item_t item_i,
  hsi2rgbw_out_if.source      out_o
);
  import hsi2rgbw_pkg::*;

  localparam int unsigned MUL_W = 36;
  localparam int unsigned PA_W  = SAT_W + FACTOR_W;
  localparam int unsigned PR_W  = SAT_W + SAT_W;
  localparam int unsigned SC_W  = PA_W + 8;

  function automatic logic [CHAN_W-1:0] chan3(input logic [PA_W-1:0] p);
    logic [SC_W-1:0] t;
    logic [10:0]     v;
    logic [21:0]     m;
    logic [10:0]     d;
    t = {p, 8'b0} - SC_W'(p);
    v = t[SC_W-1:32];
    m = 22'(v) * 22'(683);
    d = m[21:11];
    return (d > 11'd255) ? CHAN_W'(255) : d[CHAN_W-1:0];
  endfunction

  function automatic logic [CHAN_W-1:0] chanw(input logic [PR_W-1:0] p);
    logic [PR_W+7:0] t;
    logic [PR_W-25:0] v;
    t = {p, 8'b0} - (PR_W + 8)'(p);
    v = t[PR_W+7:32];
    return (v > (PR_W - 24)'(255)) ? CHAN_W'(255) : v[CHAN_W-1:0];
  endfunction

  logic                b1_valid_q;
  sector_e             b1_sector_q;
  mode_e               b1_mode_q;
  logic [FACTOR_W-1:0] b1_fa_q;
  logic [FACTOR_W-1:0] b1_fb_q;
  logic [SAT_W-1:0]    b1_rest_q;
  logic [SAT_W-1:0]    b1_int_q;

  logic                b2_valid_q;
  sector_e             b2_sector_q;
  mode_e               b2_mode_q;
  logic [PA_W-1:0]     b2_pa_q;
  logic [PA_W-1:0]     b2_pb_q;
  logic [PR_W-1:0]     b2_pr_q;

  logic                o_valid_q;
  logic [CHAN_W-1:0]   red_q, green_q, blue_q, white_q;
  logic [CHAN_W-1:0]   red_d, green_d, blue_d, white_d;

  logic                b1_adv, b2_adv, o_adv;
  logic signed [FACTOR_W-1:0] a_mul, b_mul;
  logic signed [FACTOR_W-1:0] s_sgn;
  logic signed [MUL_W-1:0]    base;
  logic signed [MUL_W-1:0]    fa, fb;
  logic [FACTOR_W-1:0]        fa_f, fb_f;
  logic [CHAN_W-1:0]          lead, trail, rest_c;

  assign o_adv        = !o_valid_q || out_o.ready;
  assign b2_adv       = !b2_valid_q || o_adv;
  assign b1_adv       = !b1_valid_q || b2_adv;
  assign item_ready_o = b1_adv;

  always_comb begin
    s_sgn = signed'(FACTOR_W'(item_i.sat));
    if (mode_i == MODE_RGBW) begin
      a_mul = FACTOR_W'(item_i.ratio) + FACTOR_W'(Q14_ONE);
      b_mul = FACTOR_W'(2 * Q14_ONE) - FACTOR_W'(item_i.ratio);
      base  = '0;
    end else begin
      a_mul = FACTOR_W'(item_i.ratio);
      b_mul = FACTOR_W'(Q14_ONE) - FACTOR_W'(item_i.ratio);
      base  = MUL_W'(ONE) <<< 14;
    end
    fa   = base + MUL_W'(s_sgn) * MUL_W'(a_mul);
    fb   = base + MUL_W'(s_sgn) * MUL_W'(b_mul);
    fa_f = fa[MUL_W-1] ? '0 : fa[FACTOR_W+13:14];
    fb_f = fb[MUL_W-1] ? '0 : fb[FACTOR_W+13:14];
  end

  always_comb begin
    lead  = chan3(b2_pa_q);
    trail = chan3(b2_pb_q);
    if (b2_mode_q == MODE_RGBW) begin
      rest_c  = '0;
      white_d = chanw(b2_pr_q);
    end else begin
      rest_c  = chan3(PA_W'(b2_pr_q));
      white_d = '0;
    end
    case (b2_sector_q)
      SECT_R: begin
        red_d = lead;   green_d = trail;  blue_d = rest_c;
      end
      SECT_G: begin
        red_d = rest_c; green_d = lead;   blue_d = trail;
      end
      SECT_B: begin
        red_d = trail;  green_d = rest_c; blue_d = lead;
      end
      default: begin
        red_d = '0;     green_d = '0;     blue_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
      b2_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      if (b1_adv) begin
        b1_valid_q <= item_valid_i;
      end
      if (b2_adv) begin
        b2_valid_q <= b1_valid_q;
      end
      if (o_adv) begin
        o_valid_q <= b2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b1_adv && item_valid_i) begin
      b1_sector_q <= item_i.sector;
      b1_mode_q   <= mode_i;
      b1_fa_q     <= fa_f;
      b1_fb_q     <= fb_f;
      b1_rest_q   <= ONE - item_i.sat;
      b1_int_q    <= item_i.inten;
    end
    if (b2_adv && b1_valid_q) begin
      b2_sector_q <= b1_sector_q;
      b2_mode_q   <= b1_mode_q;
      b2_pa_q     <= PA_W'(b1_int_q) * PA_W'(b1_fa_q);
      b2_pb_q     <= PA_W'(b1_int_q) * PA_W'(b1_fb_q);
      b2_pr_q     <= PR_W'(b1_int_q) * PR_W'(b1_rest_q);
    end
    if (o_adv && b2_valid_q) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      white_q <= white_d;
    end
  end

  assign out_o.valid = o_valid_q;
  assign out_o.red   = red_q;
  assign out_o.green = green_q;
  assign out_o.blue  = blue_q;
  assign out_o.white = white_q;

endmodule
`default_nettype wire

// ===== src/hsi_to_rgb_rgbw_converter.sv =====
// Top level of the HSI to RGB/RGBW converter: configuration register and block wiring.
// Depends on hsi2rgbw_pkg, both channel interfaces, front end, queue and back end.
`default_nettype none
// Takes one HSI pixel per clock and returns one LED pixel per clock at full rate while the
// output is not held; the path is two front stages (sector pick, ratio table read), the
// queue and three back stages (factors, intensity products, byte scaling).
// The queue lets the input keep flowing for a few pixels while the output is held.
// output_mode is written over the APB port at offset 0 (bit 0: 0 = RGB, 1 = RGBW); change
// it only while no pixel is in flight. There is no clearing pass after reset.
module hsi_to_rgb_rgbw_converter #(
  parameter int unsigned RATIO_TABLE_ENTRIES = hsi2rgbw_pkg::RATIO_TABLE_ENTRIES,
  parameter int unsigned QUEUE_DEPTH         = hsi2rgbw_pkg::QUEUE_DEPTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  hsi2rgbw_in_if.sink                           in_i,
  hsi2rgbw_out_if.source                        out_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [hsi2rgbw_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [hsi2rgbw_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [hsi2rgbw_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                  pready
);
  import hsi2rgbw_pkg::*;

  mode_e mode_q, mode_d;
  logic  reg_sel;
  logic  fq_valid, fq_ready;
  item_t fq_item;
  logic  qb_valid, qb_ready;
  item_t qb_item;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_IDX_OUTPUT_MODE);
  assign prdata  = reg_sel ? CFG_DATA_W'(mode_q) : '0;

  always_comb begin
    mode_d = mode_q;
    if (psel && penable && pwrite && pready && reg_sel) begin
      mode_d = mode_e'(pwdata[0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RGB;
    end else begin
      mode_q <= mode_d;
    end
  end

  hsi2rgbw_front #(
    .RATIO_TABLE_ENTRIES(RATIO_TABLE_ENTRIES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .item_valid_o(fq_valid),
    .item_ready_i(fq_ready),
    .item_o      (fq_item)
  );

  hsi2rgbw_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(fq_valid),
    .wr_ready_o(fq_ready),
    .wr_item_i (fq_item),
    .rd_valid_o(qb_valid),
    .rd_ready_i(qb_ready),
    .rd_item_o (qb_item)
  );

  hsi2rgbw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .item_valid_i(qb_valid),
    .item_ready_o(qb_ready),
    .item_i      (qb_item),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire

// ===== src/hsi2rgbw_checker.sv =====
// Port-level checks for the HSI to RGB/RGBW converter, bound to the top level.
// Depends on hsi2rgbw_pkg and the top level hsi_to_rgb_rgbw_converter.
`default_nettype none
module hsi2rgbw_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [hsi2rgbw_pkg::CHAN_W-1:0]  red_i,
  input logic [hsi2rgbw_pkg::CHAN_W-1:0]  green_i,
  input logic [hsi2rgbw_pkg::CHAN_W-1:0]  blue_i,
  input logic [hsi2rgbw_pkg::CHAN_W-1:0]  white_i
);
  import hsi2rgbw_pkg::*;

  logic [7:0] pending_q, pending_d;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (in_xfer && !out_xfer) begin
      pending_d = pending_q + 8'd1;
    end else if (out_xfer && !in_xfer) begin
      pending_d = pending_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable({red_i, green_i, blue_i, white_i}))
    else $error("output payload changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 8'd0)
    else $error("output transfer without a pixel in flight");

  a_white_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && white_i != '0 |-> red_i == '0 || green_i == '0 || blue_i == '0)
    else $error("white set without a zero colour channel");

endmodule

bind hsi_to_rgb_rgbw_converter hsi2rgbw_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .red_i      (out_o.red),
  .green_i    (out_o.green),
  .blue_i     (out_o.blue),
  .white_i    (out_o.white)
);
`default_nettype wire

// ===== tb/hsi_to_rgb_rgbw_converter_test.sv =====
// Self-checking testbench for hsi_to_rgb_rgbw_converter: directed pixel table, then random
// pixels in RGBW and RGB phases in turn, checked against a local fixed-point HSI predictor.
// Depends on hsi2rgbw_pkg, hsi2rgbw_in_if, hsi2rgbw_out_if and the converter RTL.
module hsi_to_rgb_rgbw_converter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hsi2rgbw_pkg::*;

  localparam longint      LUT_SIZE       = RATIO_TABLE_ENTRIES;
  localparam longint      TURN_THIRD_Q28 = 64'sd562209904;
  localparam longint      TURN_SIXTH_Q28 = 64'sd281104952;
  localparam longint      RATIO_UNIT     = 64'sd16384;
  localparam int unsigned CYCLE_LIMIT    = 100000;
  localparam int unsigned HOLD_CYCLES    = 120;
  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam int unsigned PHASES         = 6;
  localparam int unsigned PHASE_ITEMS    = 75;
  localparam logic [CFG_ADDR_W-1:0] ADDR_OUTPUT_MODE = CFG_ADDR_W'(4 * REG_IDX_OUTPUT_MODE);
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED    = CFG_ADDR_W'(4);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] white;
  } led_px_t;

  typedef struct packed {
    mode_e            mode;
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [SAT_W-1:0] inten;
    logic             known;
    led_px_t          px;
  } pixel_row_t;

  localparam logic [SAT_W-1:0] SAT_MAX = '1;

  pixel_row_t pixel_plan [20] = '{
    '{MODE_RGB,  16'd0,     17'd0,      17'd0,      1'b1, '{8'd0,  8'd0,  8'd0,  8'd0}},
    '{MODE_RGB,  16'd0,     17'd0,      ONE,        1'b1, '{8'd85, 8'd85, 8'd85, 8'd0}},
    '{MODE_RGB,  16'd65535, 17'd0,      SAT_MAX,    1'b1, '{8'd85, 8'd85, 8'd85, 8'd0}},
    '{MODE_RGB,  16'd0,     ONE,        ONE,        1'b0, '0},
    '{MODE_RGB,  16'd21845, ONE,        ONE,        1'b0, '0},
    '{MODE_RGB,  16'd21846, ONE,        ONE,        1'b0, '0},
    '{MODE_RGB,  16'd43690, ONE,        ONE,        1'b0, '0},
    '{MODE_RGB,  16'd43691, ONE,        ONE,        1'b0, '0},
    '{MODE_RGB,  16'd65535, SAT_MAX,    SAT_MAX,    1'b0, '0},
    '{MODE_RGB,  16'h5555,  SAT_MAX,    ONE,        1'b0, '0},
    '{MODE_RGB,  16'd0,     17'd65535,  17'd65535,  1'b0, '0},
    '{MODE_RGB,  16'd32768, 17'd32768,  SAT_MAX,    1'b0, '0},
    '{MODE_RGBW, 16'd0,     17'd0,      ONE,        1'b1, '{8'd0,  8'd0,  8'd0,  8'd255}},
    '{MODE_RGBW, 16'd0,     17'd0,      17'd0,      1'b1, '{8'd0,  8'd0,  8'd0,  8'd0}},
    '{MODE_RGBW, 16'd0,     ONE,        ONE,        1'b0, '0},
    '{MODE_RGBW, 16'd21845, SAT_MAX,    SAT_MAX,    1'b0, '0},
    '{MODE_RGBW, 16'd21846, ONE,        ONE,        1'b0, '0},
    '{MODE_RGBW, 16'd43691, 17'd40000,  17'd100000, 1'b0, '0},
    '{MODE_RGBW, 16'd65535, 17'd1,      ONE,        1'b0, '0},
    '{MODE_RGBW, 16'd12345, 17'd0,      SAT_MAX,    1'b1, '{8'd0,  8'd0,  8'd0,  8'd255}}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  hsi2rgbw_in_if  pix_in ();
  hsi2rgbw_out_if pix_out ();

  hsi_to_rgb_rgbw_converter u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (pix_in),
    .out_o   (pix_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  longint      ratio_lut [LUT_SIZE];
  led_px_t     pending_px [$];
  mode_e       cur_mode;
  int unsigned error_count;
  int unsigned cycle_count;
  bit          hold_req;
  bit          no_idle;
  int unsigned burst_left;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("tb: mismatch on %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  function automatic longint taylor_cos(longint ang);
    longint unsigned mag;
    longint unsigned sq;
    longint unsigned term;
    longint          acc;
    int              n;
    mag  = (ang < 0) ? -ang : ang;
    sq   = (mag * mag) >> 28;
    term = 64'd1 << 28;
    acc  = longint'(term);
    for (n = 1; n <= 12; n++) begin
      term = (term * sq) >> 28;
      term = term / longint'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    return acc;
  endfunction

  function automatic void build_ratio_lut();
    longint angle;
    longint num;
    longint den;
    longint mag;
    longint ratio;
    for (longint k = 0; k < LUT_SIZE; k++) begin
      angle = (k * TURN_THIRD_Q28) / LUT_SIZE;
      num   = taylor_cos(angle);
      den   = taylor_cos(TURN_SIXTH_Q28 - angle);
      mag   = (num < 0) ? -num : num;
      if (den <= 0) begin
        den = 1;
      end
      ratio        = (mag * RATIO_UNIT + den / 2) / den;
      ratio_lut[k] = (num < 0) ? -ratio : ratio;
    end
  endfunction

  function automatic logic [CHAN_W-1:0] scale_chan(longint inten, longint factor,
                                                   longint divisor);
    longint v;
    if (factor < 0) begin
      factor = 0;
    end
    v = (255 * inten * factor) / divisor;
    return (v > 255) ? 8'd255 : v[CHAN_W-1:0];
  endfunction

  function automatic led_px_t convert_pixel(mode_e mode, logic [HUE_W-1:0] hue,
                                            logic [SAT_W-1:0] sat_in,
                                            logic [SAT_W-1:0] int_in);
    longint  unit;
    longint  s;
    longint  i;
    longint  h3;
    longint  pos;
    longint  idx;
    longint  q;
    longint  fa;
    longint  fb;
    longint  lead;
    longint  trail;
    longint  rest;
    sector_e sector;
    led_px_t px;
    unit = longint'(1) << FRACTION_BITS;
    s    = longint'(sat_in);
    i    = longint'(int_in);
    if (s > unit) begin
      s = unit;
    end
    if (i > unit) begin
      i = unit;
    end
    h3 = longint'(hue) * 3;
    if (h3 < 65536) begin
      sector = SECT_R;
      pos    = h3;
    end else if (h3 < 131072) begin
      sector = SECT_G;
      pos    = h3 - 65536;
    end else begin
      sector = SECT_B;
      pos    = h3 - 131072;
    end
    idx = (pos * LUT_SIZE) >>> 16;
    if (idx >= LUT_SIZE) begin
      idx = LUT_SIZE - 1;
    end
    q        = ratio_lut[idx];
    px.white = '0;
    if (mode == MODE_RGB) begin
      fa    = (unit << 14) + s * q;
      fb    = (unit << 14) + s * (RATIO_UNIT - q);
      lead  = scale_chan(i, (fa < 0) ? 0 : (fa >>> 14), 3 * unit * unit);
      trail = scale_chan(i, (fb < 0) ? 0 : (fb >>> 14), 3 * unit * unit);
      rest  = scale_chan(i, unit - s, 3 * unit * unit);
    end else begin
      fa       = s * (RATIO_UNIT + q);
      fb       = s * (2 * RATIO_UNIT - q);
      lead     = scale_chan(i, (fa < 0) ? 0 : (fa >>> 14), 3 * unit * unit);
      trail    = scale_chan(i, (fb < 0) ? 0 : (fb >>> 14), 3 * unit * unit);
      rest     = 0;
      px.white = scale_chan(i, unit - s, unit * unit);
    end
    case (sector)
      SECT_R: begin
        px.red   = lead[CHAN_W-1:0];
        px.green = trail[CHAN_W-1:0];
        px.blue  = rest[CHAN_W-1:0];
      end
      SECT_G: begin
        px.red   = rest[CHAN_W-1:0];
        px.green = lead[CHAN_W-1:0];
        px.blue  = trail[CHAN_W-1:0];
      end
      default: begin
        px.red   = trail[CHAN_W-1:0];
        px.green = rest[CHAN_W-1:0];
        px.blue  = lead[CHAN_W-1:0];
      end
    endcase
    return px;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) begin
      return 0;
    end else if (r < 94) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [SAT_W-1:0] pick_level();
    case ($urandom_range(9))
      0, 1, 2, 3: return SAT_W'($urandom_range(0, ONE));
      4, 5, 6:    return SAT_W'($urandom_range(0, SAT_MAX));
      7:          return '0;
      8:          return ONE;
      default:    return ($urandom_range(1) == 1) ? SAT_MAX : SAT_W'(ONE + 1);
    endcase
  endfunction

  function automatic logic [HUE_W-1:0] pick_hue();
    case ($urandom_range(7))
      0:       return HUE_W'(21845 + $urandom_range(0, 2) - 1);
      1:       return HUE_W'(43690 + $urandom_range(0, 2));
      2:       return ($urandom_range(1) == 1) ? 16'd0 : 16'd65535;
      default: return HUE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Caller stands at a falling edge; returns at the falling edge after the transfer.
  task automatic push_pixel(logic [HUE_W-1:0] hue, logic [SAT_W-1:0] sat,
                            logic [SAT_W-1:0] inten, logic known, led_px_t known_px);
    pix_in.valid      <= 1'b1;
    pix_in.hue        <= hue;
    pix_in.saturation <= sat;
    pix_in.intensity  <= inten;
    do begin
      @(posedge clk_i);
    end while (!pix_in.ready);
    pending_px.push_back(known ? known_px : convert_pixel(cur_mode, hue, sat, inten));
    @(negedge clk_i);
  endtask

  task automatic drain_pixels();
    pix_in.valid <= 1'b0;
    wait (pending_px.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_OUTPUT_MODE) begin
      cur_mode = mode_e'(data[0]);
    end
    @(negedge clk_i);
  endtask

  task automatic check_mode_reg();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_OUTPUT_MODE;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== CFG_DATA_W'(cur_mode)) begin
      report_mismatch("output_mode readback", prdata, cur_mode);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_mode(mode_e mode);
    apb_write(ADDR_OUTPUT_MODE,
              (CFG_DATA_W'($urandom()) & ~CFG_DATA_W'(1)) | CFG_DATA_W'(mode));
    apb_write(ADDR_UNMAPPED, CFG_DATA_W'($urandom()));
    check_mode_reg();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pix_out.valid && pix_out.ready) begin
      if (pending_px.size() == 0) begin
        report_mismatch("unexpected pixel, red", pix_out.red, 0);
      end else begin
        led_px_t want;
        want = pending_px.pop_front();
        if (pix_out.red !== want.red) report_mismatch("red", pix_out.red, want.red);
        if (pix_out.green !== want.green) report_mismatch("green", pix_out.green, want.green);
        if (pix_out.blue !== want.blue) report_mismatch("blue", pix_out.blue, want.blue);
        if (pix_out.white !== want.white) report_mismatch("white", pix_out.white, want.white);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int unsigned stall;
    pix_out.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        pix_out.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        stall = no_idle ? 0 : pick_gap();
        if (stall > 0) begin
          pix_out.ready <= 1'b0;
          repeat (stall - 1) @(negedge clk_i);
        end else begin
          pix_out.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    int unsigned gap;
    mode_e       phase_mode;
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    pix_in.valid      = 1'b0;
    pix_in.hue        = '0;
    pix_in.saturation = '0;
    pix_in.intensity  = '0;
    cur_mode          = MODE_RGB;
    error_count       = 0;
    cycle_count       = 0;
    hold_req          = 1'b0;
    no_idle           = 1'b0;
    burst_left        = 0;
    build_ratio_lut();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    check_mode_reg();
    set_mode(MODE_RGB);

    foreach (pixel_plan[r]) begin
      if (pixel_plan[r].mode != cur_mode) begin
        drain_pixels();
        set_mode(pixel_plan[r].mode);
      end
      push_pixel(pixel_plan[r].hue, pixel_plan[r].sat, pixel_plan[r].inten,
                 pixel_plan[r].known, pixel_plan[r].px);
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_pixels();
      phase_mode = (p % 2 == 0) ? MODE_RGBW : MODE_RGB;
      set_mode(phase_mode);
      no_idle = (p == 1);
      if (p == 2) begin
        hold_req   = 1'b1;
        burst_left = 40;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == PHASE_ITEMS / 2) begin
          drain_pixels();
        end
        gap = (no_idle || burst_left > 0) ? 0 : pick_gap();
        if (burst_left > 0) begin
          burst_left--;
        end
        if (gap > 0) begin
          pix_in.valid <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        push_pixel(pick_hue(), pick_level(), pick_level(), 1'b0, '0);
      end
    end
    no_idle = 1'b0;

    pix_in.valid <= 1'b0;
    wait (pending_px.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
